FILE: rtl/glyph_bitmap_expander_top_assert.svh
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_top_assert.svh
// Assertion macros for the glyph bitmap expander. Each macro expands to one
// labeled concurrent assertion clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BITMAP_EXPANDER_TOP_ASSERT_SVH
`define GLYPH_BITMAP_EXPANDER_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define GBE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph expander check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define GBE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph expander check failed");

`endif

FILE: rtl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants of the glyph bitmap expander.
// ----------------------------------------------------------------------------
package gbe_pkg;

  // Default sizes.
  localparam int FONT_BYTES_DEF     = 2048;
  localparam int MAX_GLYPH_SIDE_DEF = 8;

  // Fixed field widths.
  localparam int ACT_W      = 1;
  localparam int FADDR_W    = 11;
  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 8;
  localparam int ORIGIN_W   = 8;
  localparam int COORD_W    = 9;
  localparam int COLOR_W    = 16;
  localparam int DIM_W      = 4;
  localparam int ROW_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
  localparam logic [ACT_W-1:0] ACT_DRAW  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH      = 2'd0,
    REG_GLYPH_HEIGHT     = 2'd1,
    REG_TEXT_COLOR       = 2'd2,
    REG_BACKGROUND_COLOR = 2'd3
  } cfg_reg_t;

  // Input request.
  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [FADDR_W-1:0]  font_address;
    logic [BYTE_W-1:0]   font_byte;
    logic [CODE_W-1:0]   char_code;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
  } req_t;

  // Output pixel.
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_t;

  // Per-pixel tag that travels beside a font memory read.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ROW_W-1:0]   row;
    logic               last;
  } issue_t;

endpackage

FILE: rtl/gbe_font_ram.sv
// ----------------------------------------------------------------------------
// gbe_font_ram
// Font store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbe_font_ram #(
  parameter int DEPTH = gbe_pkg::FONT_BYTES_DEF,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AddrW-1:0]          wr_addr,
  input  logic [gbe_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AddrW-1:0]          rd_addr,
  output logic [gbe_pkg::BYTE_W-1:0] rd_data
);
  import gbe_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gbe_seq.sv
// ----------------------------------------------------------------------------
// gbe_seq
// Request sequencer: stores font bytes, computes the glyph base address and
// walks the glyph in row-major order, issuing one font read per pixel.
// ----------------------------------------------------------------------------
module gbe_seq #(
  parameter int FONT_BYTES     = gbe_pkg::FONT_BYTES_DEF,
  parameter int MAX_GLYPH_SIDE = gbe_pkg::MAX_GLYPH_SIDE_DEF,
  localparam int AddrW = $clog2(FONT_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  gbe_pkg::req_t               req,
  input  logic [gbe_pkg::DIM_W-1:0]   glyph_width,
  input  logic [gbe_pkg::DIM_W-1:0]   glyph_height,
  input  logic                        issue_ok,
  output gbe_pkg::issue_t             issue,
  output logic [AddrW-1:0]            rd_addr,
  output logic                        wr_en,
  output logic [AddrW-1:0]            wr_addr,
  output logic [gbe_pkg::BYTE_W-1:0]  wr_data
);
  import gbe_pkg::*;

  localparam int CntW  = $clog2(MAX_GLYPH_SIDE + 1);
  localparam int BaseW = AddrW + 2;
  localparam int StepW = $clog2(CODE_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BASE = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t              state;
  logic [CntW-1:0]     w_clamp, h_clamp;
  logic [CntW-1:0]     w_eff, h_eff;
  logic [CntW-1:0]     col, row;
  logic [CODE_W-1:0]   code_sh;
  logic [StepW-1:0]    step;
  logic [ORIGIN_W-1:0] ox, oy;
  logic [AddrW-1:0]    base, col_addr, col_addr_inc;
  logic [BaseW-1:0]    dbl;
  logic [AddrW-1:0]    base_next;
  logic                accept, draw_go, issue_fire, col_end, row_end;

  // Clamp the configured sides to the largest glyph.
  assign w_clamp = (glyph_width > DIM_W'(MAX_GLYPH_SIDE)) ?
                   CntW'(MAX_GLYPH_SIDE) : CntW'(glyph_width);
  assign h_clamp = (glyph_height > DIM_W'(MAX_GLYPH_SIDE)) ?
                   CntW'(MAX_GLYPH_SIDE) : CntW'(glyph_height);

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign draw_go   = accept && (req.action == ACT_DRAW) &&
                     (w_clamp != '0) && (h_clamp != '0);

  // Font writes go straight to the memory; addresses past the end are dropped.
  assign wr_en   = accept && (req.action == ACT_WRITE) &&
                   (32'(req.font_address) < FONT_BYTES);
  assign wr_addr = AddrW'(req.font_address);
  assign wr_data = req.font_byte;

  // One shift-add step of code*width modulo the store size, MSB of code first.
  always_comb begin
    dbl = BaseW'({base, 1'b0}) + (code_sh[CODE_W-1] ? BaseW'(w_eff) : '0);
    if (dbl >= BaseW'(2 * FONT_BYTES)) begin
      base_next = AddrW'(dbl - BaseW'(2 * FONT_BYTES));
    end else if (dbl >= BaseW'(FONT_BYTES)) begin
      base_next = AddrW'(dbl - BaseW'(FONT_BYTES));
    end else begin
      base_next = AddrW'(dbl);
    end
  end

  // Column address step with wrap at the end of the store.
  assign col_addr_inc = (col_addr == AddrW'(FONT_BYTES - 1)) ? '0 : AddrW'(col_addr + 1'b1);

  assign issue_fire = (state == ST_EMIT) && issue_ok;
  assign col_end    = (col == CntW'(w_eff - 1'b1));
  assign row_end    = (row == CntW'(h_eff - 1'b1));

  // Read request and pixel tag.
  always_comb begin
    issue.valid = issue_fire;
    issue.x     = COORD_W'(ox) + COORD_W'(col);
    issue.y     = COORD_W'(oy) + COORD_W'(row);
    issue.row   = ROW_W'(row);
    issue.last  = col_end && row_end;
  end
  assign rd_addr = col_addr;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (draw_go) begin
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          if (step == StepW'(CODE_W - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (issue_fire && col_end && row_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Draw context, base address and counters.
  always_ff @(posedge clk) begin
    if (draw_go) begin
      w_eff   <= w_clamp;
      h_eff   <= h_clamp;
      code_sh <= req.char_code;
      ox      <= req.origin_x;
      oy      <= req.origin_y;
      base    <= '0;
      step    <= '0;
    end else if (state == ST_BASE) begin
      base     <= base_next;
      code_sh  <= {code_sh[CODE_W-2:0], 1'b0};
      step     <= StepW'(step + 1'b1);
      col_addr <= base_next;
      col      <= '0;
      row      <= '0;
    end else if (issue_fire) begin
      if (col_end) begin
        col      <= '0;
        col_addr <= base;
        row      <= CntW'(row + 1'b1);
      end else begin
        col      <= CntW'(col + 1'b1);
        col_addr <= col_addr_inc;
      end
    end
  end

endmodule

FILE: rtl/gbe_pix_out.sv
// ----------------------------------------------------------------------------
// gbe_pix_out
// Pixel output stage: holds the tag of the read in flight, picks the glyph
// bit from the returned column byte and registers the pixel for the output.
// ----------------------------------------------------------------------------
module gbe_pix_out (
  input  logic                         clk,
  input  logic                         rst,
  input  gbe_pkg::issue_t              issue,
  output logic                         issue_ok,
  input  logic [gbe_pkg::BYTE_W-1:0]   rd_data,
  input  logic [gbe_pkg::COLOR_W-1:0]  text_color,
  input  logic [gbe_pkg::COLOR_W-1:0]  background_color,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output gbe_pkg::pix_t                pix
);
  import gbe_pkg::*;

  logic              tag_valid;
  issue_t            tag;
  logic              advance;
  logic [BYTE_W-1:0] shifted;

  // The tag stage moves on when the output register is free or being taken.
  assign advance  = !pix_valid || pix_ready;
  assign issue_ok = !tag_valid || advance;

  // Top row is the MSB of the column byte.
  assign shifted = BYTE_W'(rd_data << tag.row);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (issue.valid) begin
        tag_valid <= 1'b1;
      end else if (advance) begin
        tag_valid <= 1'b0;
      end
      if (advance) begin
        pix_valid <= tag_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      tag <= issue;
    end
    if (advance && tag_valid) begin
      pix.pixel_x <= tag.x;
      pix.pixel_y <= tag.y;
      pix.color   <= shifted[BYTE_W-1] ? text_color : background_color;
      pix.last    <= tag.last;
    end
  end

endmodule

FILE: rtl/glyph_bitmap_expander_top.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_top
// Text character generator for column-major fonts: font byte writes and
// character draws that expand a glyph into a row-major pixel stream.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Carries
//  req      req_valid / req_ready / req      in         font write or draw
//  pix      pix_valid / pix_ready / pix      out        one glyph pixel
//  cfg      cfg_we / cfg_index / cfg_data    in         register write
//
// A font write goes straight to the font store. A draw first forms the glyph base
// address (one code bit per cycle), then issues one font read per pixel, bounded
// by the single read port and held while the pix channel stalls.
// The next request is taken once the last pixel read has been issued.
// Reset clears control state only; the font store is not cleared.
// A stalled pix channel holds the pipeline; no pixel is dropped.
module glyph_bitmap_expander_top #(
  parameter int FONT_BYTES     = gbe_pkg::FONT_BYTES_DEF,
  parameter int MAX_GLYPH_SIDE = gbe_pkg::MAX_GLYPH_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  gbe_pkg::req_t                   req,
  output logic                            pix_valid,
  input  logic                            pix_ready,
  output gbe_pkg::pix_t                   pix,
  input  logic                            cfg_we,
  input  logic [gbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gbe_pkg::*;

`include "glyph_bitmap_expander_top_assert.svh"

  localparam int AddrW = $clog2(FONT_BYTES);

  logic [DIM_W-1:0]   glyph_width, glyph_height;
  logic [COLOR_W-1:0] text_color, background_color;
  issue_t             issue;
  logic               issue_ok;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               wr_en;
  logic [BYTE_W-1:0]  wr_data, rd_data;
  logic               draw_taken;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width      <= DIM_W'(8);
      glyph_height     <= DIM_W'(8);
      text_color       <= 16'hFFFF;
      background_color <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GLYPH_WIDTH:      glyph_width      <= cfg_data[DIM_W-1:0];
        REG_GLYPH_HEIGHT:     glyph_height     <= cfg_data[DIM_W-1:0];
        REG_TEXT_COLOR:       text_color       <= cfg_data[COLOR_W-1:0];
        REG_BACKGROUND_COLOR: background_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Request sequencer.
  gbe_seq #(
    .FONT_BYTES     (FONT_BYTES),
    .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .issue_ok     (issue_ok),
    .issue        (issue),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Font store.
  gbe_font_ram #(
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue.valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pixel output stage.
  gbe_pix_out u_pix_out (
    .clk              (clk),
    .rst              (rst),
    .issue            (issue),
    .issue_ok         (issue_ok),
    .rd_data          (rd_data),
    .text_color       (text_color),
    .background_color (background_color),
    .pix_valid        (pix_valid),
    .pix_ready        (pix_ready),
    .pix              (pix)
  );

  // A draw with a nonempty glyph is taken in this cycle.
  assign draw_taken = req_valid && req_ready && (req.action == ACT_DRAW) &&
                      (glyph_width != '0) && (glyph_height != '0);

  // Checks on the sequencing.
  `GBE_ASSERT_IMP(a_ports_exclusive, issue.valid, !wr_en)
  `GBE_ASSERT_IMP(a_no_read_when_ready, req_ready, !issue.valid)
  `GBE_ASSERT_NEXT(a_draw_busy, draw_taken, !req_ready)
  `GBE_ASSERT_NEXT(a_last_read_frees, issue.valid && issue.last, req_ready)

endmodule

FILE: tb/glyph_bitmap_expander_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_top_tb
// Self-checking bench for the glyph bitmap expander. It loads part of the font
// store, then sends directed and random font writes and character draws under
// several glyph sizes and colors. A shadow copy of the font and the registers
// predicts every pixel, and each emitted pixel is checked field by field.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander_top_tb;
  import gbe_pkg::*;

  localparam int FONT_SIZE     = FONT_BYTES_DEF;
  localparam int SIDE_MAX      = MAX_GLYPH_SIDE_DEF;
  localparam int LOADED_BYTES  = 64;
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PRINT_CAP     = 40;

  // Column bytes of the glyph at code 0; code 255 gets the inverted pattern.
  localparam logic [63:0] EDGE_GLYPH = 64'h80_01_FF_00_AA_55_F0_0F;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  pix_valid;
  logic                  pix_ready;
  pix_t                  pix;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the font store and the registers, updated on acceptance.
  logic [BYTE_W-1:0]  font_shadow [FONT_SIZE];
  bit                 font_written [FONT_SIZE];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [COLOR_W-1:0] text_reg;
  logic [COLOR_W-1:0] back_reg;
  pix_t               expected_pixels [$];

  int mismatches;
  int pixels_checked;
  int draws_sent;
  int writes_sent;
  int settings_used;
  int cycle_count;
  int rx_hold_cycles;
  bit tx_idle_on;
  bit rx_idle_on;

  glyph_bitmap_expander_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit of %0d reached with %0d pixels outstanding.",
               CYCLE_LIMIT, expected_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
    end
  endtask

  // Expands one draw request into the pixels it must produce.
  function automatic void expand_glyph(input req_t r);
    int                w;
    int                h;
    int                addr;
    logic [BYTE_W-1:0] column;
    pix_t              p;
    w = (width_reg > SIDE_MAX) ? SIDE_MAX : int'(width_reg);
    h = (height_reg > SIDE_MAX) ? SIDE_MAX : int'(height_reg);
    for (int row = 0; row < h; row++) begin
      for (int col = 0; col < w; col++) begin
        addr = (int'(r.char_code) * w + col) % FONT_SIZE;
        column = font_shadow[addr];
        p.pixel_x = COORD_W'(int'(r.origin_x) + col);
        p.pixel_y = COORD_W'(int'(r.origin_y) + row);
        p.color = column[BYTE_W-1-row] ? text_reg : back_reg;
        p.last = (row == h - 1) && (col == w - 1);
        expected_pixels.push_back(p);
      end
    end
  endfunction

  // Applies an accepted request to the shadow state.
  function automatic void apply_request(input req_t r);
    if (r.action == ACT_WRITE) begin
      font_shadow[r.font_address] = r.font_byte;
      font_written[r.font_address] = 1'b1;
      writes_sent++;
    end else begin
      expand_glyph(r);
      draws_sent++;
    end
  endfunction

  // Check each pixel against the oldest expectation.
  always @(posedge clk) begin : pixel_check
    pix_t want;
    if (!rst && pix_valid && pix_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", 64'(pix), 64'd0);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pix.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", 64'(pix.pixel_x), 64'(want.pixel_x));
        if (pix.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", 64'(pix.pixel_y), 64'(want.pixel_y));
        if (pix.color !== want.color)
          report_mismatch("color", 64'(pix.color), 64'(want.color));
        if (pix.last !== want.last)
          report_mismatch("last", 64'(pix.last), 64'(want.last));
      end
    end
  end

  // Pixel receiver: random stalls, plus a long hold-off on request.
  initial begin : pixel_receiver
    int stall;
    pix_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        pix_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        pix_ready <= 1'b1;
      end
    end
  end

  // Gap before the next request: mostly none or short, a few long.
  function automatic int pick_tx_gap();
    int roll;
    if (!tx_idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offers one request and waits until it is accepted.
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    apply_request(r);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // Waits until every expected pixel has come out and the block is quiet.
  task automatic wait_drained();
    stop_requests();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Requests carry random noise in the fields their action does not use.
  function automatic req_t noise_req();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(req_t)-1:0];
  endfunction

  function automatic req_t font_req(input int addr, input int value);
    req_t r;
    r = noise_req();
    r.action = ACT_WRITE;
    r.font_address = FADDR_W'(addr);
    r.font_byte = BYTE_W'(value);
    return r;
  endfunction

  function automatic req_t draw_req(input int code, input int ox, input int oy);
    req_t r;
    r = noise_req();
    r.action = ACT_DRAW;
    r.char_code = CODE_W'(code);
    r.origin_x = ORIGIN_W'(ox);
    r.origin_y = ORIGIN_W'(oy);
    return r;
  endfunction

  // True when every column byte of the glyph at this width has been written.
  function automatic bit glyph_written(input int code, input int w);
    for (int col = 0; col < w; col++) begin
      if (!font_written[(code * w + col) % FONT_SIZE]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A random code whose glyph is fully written at the current width; the
  // loaded low region always holds a fallback.
  function automatic int pick_code();
    int w;
    int code;
    w = (width_reg > SIDE_MAX) ? SIDE_MAX : int'(width_reg);
    for (int t = 0; t < 8; t++) begin
      code = $urandom_range(0, 255);
      if (glyph_written(code, w)) return code;
    end
    if (w == 0) return $urandom_range(0, 255);
    return $urandom_range(0, LOADED_BYTES / w - 1);
  endfunction

  function automatic req_t random_draw();
    return draw_req(pick_code(), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Writes one register; only called while the block is idle.
  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= CFG_DATA_W'($urandom);
    case (idx)
      REG_GLYPH_WIDTH:      width_reg = value[DIM_W-1:0];
      REG_GLYPH_HEIGHT:     height_reg = value[DIM_W-1:0];
      REG_TEXT_COLOR:       text_reg = value;
      REG_BACKGROUND_COLOR: back_reg = value;
      default: ;
    endcase
  endtask

  // Sizes go in the low nibble; the unused upper bits carry noise.
  task automatic apply_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom);
    value[DIM_W-1:0] = w;
    set_register(REG_GLYPH_WIDTH, value);
    value = CFG_DATA_W'($urandom);
    value[DIM_W-1:0] = h;
    set_register(REG_GLYPH_HEIGHT, value);
    set_register(REG_TEXT_COLOR, fg);
    set_register(REG_BACKGROUND_COLOR, bg);
    settings_used++;
  endtask

  // Mostly legal sides, sometimes zero or above the saturation point.
  function automatic logic [DIM_W-1:0] pick_side();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return DIM_W'($urandom_range(SIDE_MAX + 1, 15));
    return DIM_W'($urandom_range(1, SIDE_MAX));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COLOR_W'($urandom);
  endfunction

  // Fills the low font region and the full-width glyph of the highest code,
  // so that every draw reads only written entries.
  task automatic test_font_load();
    int value;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int a = 0; a < LOADED_BYTES; a++) begin
      if (a < 8)
        value = EDGE_GLYPH[63 - 8 * a -: 8];
      else
        value = $urandom_range(0, 255);
      send_request(font_req(a, value));
    end
    for (int a = FONT_SIZE - 8; a < FONT_SIZE; a++) begin
      value = ~EDGE_GLYPH[63 - 8 * (a - (FONT_SIZE - 8)) -: 8];
      send_request(font_req(a, value));
    end
  endtask

  // Extreme codes and origins at reset settings, a rewrite followed by a
  // draw of the same glyph, swapped colors and equal colors.
  task automatic test_directed_draws();
    send_request(draw_req(0, 0, 0));
    send_request(draw_req(255, 255, 255));
    send_request(draw_req(0, 255, 0));
    send_request(draw_req(255, 0, 255));
    send_request(font_req(8, 8'hFF));
    send_request(draw_req(1, 17, 99));
    send_request(font_req(FONT_SIZE - 1, 8'h00));
    send_request(draw_req(255, 200, 250));
    wait_drained();
    apply_config(4'd8, 4'd8, 16'h0000, 16'hFFFF);
    send_request(draw_req(0, 128, 64));
    send_request(draw_req(6, 85, 170));
    wait_drained();
    apply_config(4'd8, 4'd8, 16'h5AA5, 16'h5AA5);
    send_request(draw_req(7, 3, 250));
  endtask

  // Small, odd, saturating and empty glyph sizes.
  task automatic test_glyph_sizes();
    logic [2*DIM_W-1:0] sizes [10];
    sizes = '{8'h11, 8'h81, 8'h18, 8'h35, 8'h78, 8'hFF, 8'h9C, 8'h04, 8'h40, 8'h00};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (sizes[i]) begin
      wait_drained();
      apply_config(sizes[i][2*DIM_W-1:DIM_W], sizes[i][DIM_W-1:0], pick_color(), pick_color());
      send_request(random_draw());
      send_request(draw_req(pick_code(), 255, 0));
    end
  endtask

  // Random mix of writes and draws over several random settings.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      apply_config(pick_side(), pick_side(), pick_color(), pick_color());
      tx_idle_on = (phase % 3 != 0);
      rx_idle_on = (phase % 2 != 0);
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_request(font_req($urandom_range(0, FONT_SIZE - 1), $urandom_range(0, 255)));
        else
          send_request(random_draw());
      end
    end
  endtask

  // Long receiver hold-off while draws keep coming, then a sender pause
  // until every pixel is out, then a few more draws.
  task automatic test_backpressure();
    wait_drained();
    apply_config(4'd8, 4'd8, pick_color(), pick_color());
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    rx_hold_cycles = 400;
    repeat (6) send_request(random_draw());
    stop_requests();
    while (expected_pixels.size() != 0) @(posedge clk);
    tx_idle_on = 1'b1;
    repeat (4) send_request(random_draw());
  endtask

  initial begin : main_sequence
    int drain_wait;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    width_reg = 4'd8;
    height_reg = 4'd8;
    text_reg = 16'hFFFF;
    back_reg = 16'h0000;
    mismatches = 0;
    pixels_checked = 0;
    draws_sent = 0;
    writes_sent = 0;
    settings_used = 1;
    cycle_count = 0;
    rx_hold_cycles = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_font_load();
    test_directed_draws();
    test_glyph_sizes();
    test_random_traffic();
    test_backpressure();

    // Drain what is left, then give the block time to show extra pixels.
    stop_requests();
    drain_wait = 0;
    while (expected_pixels.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch("pixels never emitted", 64'(expected_pixels.size()), 64'd0);

    $display("Sent %0d font writes and %0d draws across %0d register settings.",
             writes_sent, draws_sent, settings_used);
    $display("Checked %0d pixels with %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
